/* hdl/pre_pkg.sv */
// Shared types, register codes and helper functions for the page replacement engine.
// Used by page_replacement_engine and the testbench; depends on nothing.
package pre_pkg;

  localparam int FRAMES   = 512;
  localparam int FRAME_AW = 9;
  localparam int PAGES    = 256;
  localparam int PAGE_AW  = 8;
  localparam int STAMP_W  = 40;
  localparam int MAX_PPG  = 64;

  typedef enum logic [2:0] {
    REG_POLICY  = 3'd0,
    REG_PREPAGE = 3'd1,
    REG_SHIFT   = 3'd2,
    REG_PCOUNT  = 3'd3,
    REG_PPG0    = 3'd4,
    REG_PPG1    = 3'd5,
    REG_PPG2    = 3'd6,
    REG_PPG3    = 3'd7
  } reg_idx_t;

  localparam logic [1:0] MODE_FIFO = 2'd0;
  localparam logic [1:0] MODE_LRU  = 2'd1;

  typedef struct packed {
    logic                valid;
    logic                refbit;
    logic [PAGE_AW-1:0]  page;
  } frame_ent_t;

  typedef struct packed {
    logic                res;
    logic [FRAME_AW-1:0] frame;
    logic [STAMP_W-1:0]  stamp;
  } page_ent_t;

  localparam int FRAME_EW = $bits(frame_ent_t);
  localparam int PAGE_EW  = $bits(page_ent_t);

  // Frame count for a page shift; never zero.
  function automatic logic [9:0] num_frames(input logic [3:0] shift);
    logic [9:0] nf;
    nf = 10'd512 >> shift;
    if (nf == 10'd0) nf = 10'd1;
    return nf;
  endfunction

  // Frames per process at preload: frame count divided by process count.
  function automatic logic [9:0] share_of(input logic [9:0] nf, input logic [2:0] np);
    logic [9:0] s;
    case (np)
      3'd2: s = nf >> 1;
      3'd3: begin
        case (nf)
          10'd512: s = 10'd170;
          10'd256: s = 10'd85;
          10'd128: s = 10'd42;
          10'd64:  s = 10'd21;
          10'd32:  s = 10'd10;
          10'd16:  s = 10'd5;
          10'd8:   s = 10'd2;
          10'd4:   s = 10'd1;
          default: s = 10'd0;
        endcase
      end
      3'd4:    s = nf >> 2;
      default: s = nf;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] clamp_pages(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) r = 7'd1;
    else if (v > 7'(MAX_PPG)) r = 7'(MAX_PPG);
    return r;
  endfunction

endpackage

/* hdl/page_replacement_engine.sv */
// Top level of the page replacement engine: sequencer, configuration registers,
// and the frame and page tables. Depends on pre_pkg and pre_ram.
//
// Usage. Each request on the in_ channel is one memory reference (process id,
// one-based location). The block answers each request with one result on the
// out_ channel: fault flag, frame now holding the page, eviction and pre-page
// flags, the running fault count, and a flag for rejected references.
// A request is taken when in_valid is high and in_stall is low; in_stall is
// low only while the sequencer is idle, so one request is worked at a time.
// After reset the block runs a clearing pass over the 512-entry frame table
// (and the 256-entry page table alongside it) with in_stall high; configuration
// writes over the APB port are taken as ever during that time. The first
// request after reset preloads frames, split evenly among the processes;
// configuration is frozen once the preload is done. A hit updates the page
// stamp and the frame's reference bit without a frame-table scan. A fault
// scans the frame table for an empty frame (one frame a cycle, only until the
// table is found full), then picks a victim: FIFO at the hand, LRU by a
// pipelined scan of all frames, Clock by stepping the hand past set reference
// bits and clearing each. Pre-paging adds a scan of the page table (one page a
// cycle) and a second load. The worst case is two empty-frame scans around a
// page-table scan. A finished result waits until the output register is free,
// then sits there until out_stall is low; the next request is taken once the
// result has moved into the output register.
module page_replacement_engine (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_process_id,
  input  logic [15:0] in_location,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_page_fault,
  output logic [8:0]  out_frame_used,
  output logic        out_evicted_valid,
  output logic        out_prefetch_done,
  output logic [31:0] out_fault_total,
  output logic        out_bad_reference,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [14:0] {
    S_CLEAR    = 15'b000000000000001,
    S_IDLE     = 15'b000000000000010,
    S_PRELOAD  = 15'b000000000000100,
    S_CHECK    = 15'b000000000001000,
    S_LOOK     = 15'b000000000010000,
    S_FILL     = 15'b000000000100000,
    S_POLICY   = 15'b000000001000000,
    S_LRU      = 15'b000000010000000,
    S_CLK_RD   = 15'b000000100000000,
    S_CLK_CHK  = 15'b000001000000000,
    S_EV_RD    = 15'b000010000000000,
    S_EV_WR    = 15'b000100000000000,
    S_EV_CLR   = 15'b001000000000000,
    S_PRE_SCAN = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_t;

  // Control registers.
  state_t        state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic          prep_r, prep_nxt;
  logic [3:0]    shift_r, shift_nxt;
  logic [2:0]    pcnt_r, pcnt_nxt;
  logic [6:0]    ppg_r [4];
  logic [6:0]    ppg_nxt [4];
  logic [9:0]    idx_r, idx_nxt;
  logic          chk_v_r, chk_v_nxt;
  logic          s2_v_r, s2_v_nxt;
  logic          best_v_r, best_v_nxt;
  logic [8:0]    hand_r, hand_nxt;
  logic [39:0]   uc_r, uc_nxt;
  logic [31:0]   fcnt_r, fcnt_nxt;
  logic          pdone_r, pdone_nxt;
  logic          full_r, full_nxt;
  logic          is_pre_r, is_pre_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    pp_r, pp_nxt;

  // Payload registers.
  logic [1:0]    pid_r, pid_nxt;
  logic [15:0]   loc_r, loc_nxt;
  logic [7:0]    g_r, g_nxt;
  logic [7:0]    tgt_r, tgt_nxt;
  logic [7:0]    c_r, c_nxt;
  logic [8:0]    chk_idx_r, chk_idx_nxt;
  logic [8:0]    s2_idx_r, s2_idx_nxt;
  logic [8:0]    best_f_r, best_f_nxt;
  logic [39:0]   best_t_r, best_t_nxt;
  logic [8:0]    victim_r, victim_nxt;
  logic [7:0]    oldg_r, oldg_nxt;
  logic [11:0]   pbf_r, pbf_nxt;
  logic [8:0]    pbg_r, pbg_nxt;
  logic [8:0]    fdem_r, fdem_nxt;
  logic          ev_r, ev_nxt, pre_r, pre_nxt, fault_r, fault_nxt, bad_r, bad_nxt;
  logic          o_fault_r, o_fault_nxt, o_ev_r, o_ev_nxt, o_pre_r, o_pre_nxt;
  logic          o_bad_r, o_bad_nxt;
  logic [8:0]    o_frame_r, o_frame_nxt;
  logic [31:0]   o_total_r, o_total_nxt;

  // Table ports.
  logic                 fr_we, pg_we;
  logic [8:0]           fr_waddr, fr_raddr;
  logic [7:0]           pg_waddr, pg_raddr;
  pre_pkg::frame_ent_t  fr_wdata, fr_rd;
  pre_pkg::page_ent_t   pg_wdata, pg_rd;
  logic [pre_pkg::FRAME_EW-1:0] fr_rdata;
  logic [pre_pkg::PAGE_EW-1:0]  pg_rdata;

  assign fr_rd = pre_pkg::frame_ent_t'(fr_rdata);
  assign pg_rd = pre_pkg::page_ent_t'(pg_rdata);

  pre_ram #(.WIDTH(pre_pkg::FRAME_EW), .DEPTH(pre_pkg::FRAMES)) u_frame_ram (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  pre_ram #(.WIDTH(pre_pkg::PAGE_EW), .DEPTH(pre_pkg::PAGES)) u_page_ram (
    .clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
    .raddr(pg_raddr), .rdata(pg_rdata)
  );

  // Derived configuration: effective process count, page counts, bases, frames.
  logic [2:0] np;
  logic [6:0] pages_eff [4];
  logic [8:0] base [5];
  logic [9:0] nf, share;
  logic [8:0] total;

  always_comb begin
    if (pcnt_r == 3'd0) np = 3'd1;
    else if (pcnt_r > 3'd4) np = 3'd4;
    else np = pcnt_r;
    for (int i = 0; i < 4; i++) begin
      pages_eff[i] = pre_pkg::clamp_pages(ppg_r[i]);
    end
    base[0] = 9'd0;
    for (int i = 0; i < 4; i++) begin
      base[i+1] = base[i] + {2'b0, pages_eff[i]};
    end
    nf    = pre_pkg::num_frames(shift_r);
    share = pre_pkg::share_of(nf, np);
    total = base[np];
  end

  // Reference decode.
  logic [15:0] page_full;
  logic        ref_bad;
  logic [7:0]  g_comb;

  always_comb begin
    page_full = (loc_r - 16'd1) >> shift_r;
    ref_bad   = ({1'b0, pid_r} >= np) || (loc_r == 16'd0) ||
                (page_full >= {9'd0, pages_eff[pid_r]});
    g_comb    = base[pid_r][7:0] + page_full[7:0];
  end

  // Configuration port.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !pdone_r;

  always_comb begin
    case (pre_pkg::reg_idx_t'(paddr[4:2]))
      pre_pkg::REG_POLICY:  prdata = {30'd0, mode_r};
      pre_pkg::REG_PREPAGE: prdata = {31'd0, prep_r};
      pre_pkg::REG_SHIFT:   prdata = {28'd0, shift_r};
      pre_pkg::REG_PCOUNT:  prdata = {29'd0, pcnt_r};
      pre_pkg::REG_PPG0:    prdata = {25'd0, ppg_r[0]};
      pre_pkg::REG_PPG1:    prdata = {25'd0, ppg_r[1]};
      pre_pkg::REG_PPG2:    prdata = {25'd0, ppg_r[2]};
      pre_pkg::REG_PPG3:    prdata = {25'd0, ppg_r[3]};
      default:              prdata = 32'd0;
    endcase
  end

  // Handshake outputs.
  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_page_fault    = o_fault_r;
  assign out_frame_used    = o_frame_r;
  assign out_evicted_valid = o_ev_r;
  assign out_prefetch_done = o_pre_r;
  assign out_fault_total   = o_total_r;
  assign out_bad_reference = o_bad_r;

  // Sequencer.
  logic       ld_start, ld_done, ld_ev;
  logic [8:0] ld_f;
  logic [8:0] hand_fix;
  logic [9:0] hand_inc;
  logic [8:0] c_inc;
  logic [11:0] pre_f;
  logic [8:0] g_inc;

  always_comb begin
    // Defaults: hold.
    state_nxt = state_r;
    mode_nxt = mode_r; prep_nxt = prep_r; shift_nxt = shift_r; pcnt_nxt = pcnt_r;
    for (int i = 0; i < 4; i++) ppg_nxt[i] = ppg_r[i];
    idx_nxt = idx_r; chk_v_nxt = chk_v_r; s2_v_nxt = s2_v_r; best_v_nxt = best_v_r;
    hand_nxt = hand_r; uc_nxt = uc_r; fcnt_nxt = fcnt_r; pdone_nxt = pdone_r;
    full_nxt = full_r; is_pre_nxt = is_pre_r; out_valid_nxt = out_valid_r; pp_nxt = pp_r;
    pid_nxt = pid_r; loc_nxt = loc_r; g_nxt = g_r; tgt_nxt = tgt_r; c_nxt = c_r;
    chk_idx_nxt = chk_idx_r; s2_idx_nxt = s2_idx_r; best_f_nxt = best_f_r;
    best_t_nxt = best_t_r; victim_nxt = victim_r; oldg_nxt = oldg_r;
    pbf_nxt = pbf_r; pbg_nxt = pbg_r; fdem_nxt = fdem_r;
    ev_nxt = ev_r; pre_nxt = pre_r; fault_nxt = fault_r; bad_nxt = bad_r;
    o_fault_nxt = o_fault_r; o_ev_nxt = o_ev_r; o_pre_nxt = o_pre_r; o_bad_nxt = o_bad_r;
    o_frame_nxt = o_frame_r; o_total_nxt = o_total_r;

    fr_we = 1'b0; fr_waddr = 9'd0; fr_wdata = '0; fr_raddr = 9'd0;
    pg_we = 1'b0; pg_waddr = 8'd0; pg_wdata = '0; pg_raddr = 8'd0;
    ld_start = 1'b0; ld_done = 1'b0; ld_ev = 1'b0; ld_f = 9'd0;

    hand_fix = ({1'b0, hand_r} >= nf) ? 9'd0 : hand_r;
    hand_inc = {1'b0, hand_r} + 10'd1;
    c_inc    = {1'b0, c_r} + 9'd1;
    g_inc    = {1'b0, g_r} + 9'd1;
    pre_f    = pbf_r + {2'b0, idx_r};

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    if (cfg_wr) begin
      case (pre_pkg::reg_idx_t'(paddr[4:2]))
        pre_pkg::REG_POLICY:  mode_nxt  = pwdata[1:0];
        pre_pkg::REG_PREPAGE: prep_nxt  = pwdata[0];
        pre_pkg::REG_SHIFT:   shift_nxt = pwdata[3:0];
        pre_pkg::REG_PCOUNT:  pcnt_nxt  = pwdata[2:0];
        pre_pkg::REG_PPG0:    ppg_nxt[0] = pwdata[6:0];
        pre_pkg::REG_PPG1:    ppg_nxt[1] = pwdata[6:0];
        pre_pkg::REG_PPG2:    ppg_nxt[2] = pwdata[6:0];
        pre_pkg::REG_PPG3:    ppg_nxt[3] = pwdata[6:0];
        default: ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        fr_we = 1'b1; fr_waddr = idx_r[8:0];
        pg_we = 1'b1; pg_waddr = idx_r[7:0];
        idx_nxt = idx_r + 10'd1;
        if (idx_r == 10'(pre_pkg::FRAMES - 1)) begin
          idx_nxt = 10'd0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          pid_nxt = in_process_id;
          loc_nxt = in_location;
          fault_nxt = 1'b0; ev_nxt = 1'b0; pre_nxt = 1'b0; bad_nxt = 1'b0;
          fdem_nxt = 9'd0; is_pre_nxt = 1'b0;
          pp_nxt = 3'd0; idx_nxt = 10'd0; pbf_nxt = 12'd0; pbg_nxt = 9'd0;
          state_nxt = pdone_r ? S_CHECK : S_PRELOAD;
        end
      end

      // Frames share*p .. share*p+n-1 get process p's first pages.
      S_PRELOAD: begin
        if (pp_r < np) begin
          if ((idx_r < share) && (idx_r < {3'd0, pages_eff[pp_r[1:0]]}) &&
              (pre_f < {2'd0, nf})) begin
            fr_we = 1'b1; fr_waddr = pre_f[8:0];
            fr_wdata = '{valid: 1'b1, refbit: 1'b0, page: pbg_r[7:0] + idx_r[7:0]};
            pg_we = 1'b1; pg_waddr = pbg_r[7:0] + idx_r[7:0];
            pg_wdata = '{res: 1'b1, frame: pre_f[8:0], stamp: 40'd0};
            idx_nxt = idx_r + 10'd1;
          end else begin
            pp_nxt  = pp_r + 3'd1;
            idx_nxt = 10'd0;
            pbf_nxt = pbf_r + {2'd0, share};
            pbg_nxt = pbg_r + {2'd0, pages_eff[pp_r[1:0]]};
          end
        end else begin
          pdone_nxt = 1'b1;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (ref_bad) begin
          bad_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          g_nxt = g_comb;
          pg_raddr = g_comb;
          uc_nxt = uc_r + 40'd1;
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        if (pg_rd.res) begin
          pg_we = 1'b1; pg_waddr = g_r;
          pg_wdata = '{res: 1'b1, frame: pg_rd.frame, stamp: uc_r};
          fr_we = 1'b1; fr_waddr = pg_rd.frame;
          fr_wdata = '{valid: 1'b1, refbit: 1'b1, page: g_r};
          fdem_nxt = pg_rd.frame;
          state_nxt = S_DONE;
        end else begin
          fault_nxt = 1'b1;
          fcnt_nxt = fcnt_r + 32'd1;
          tgt_nxt = g_r;
          ld_start = 1'b1;
        end
      end

      // Pipelined search for the lowest empty frame.
      S_FILL: begin
        fr_raddr = idx_r[8:0];
        chk_v_nxt = (idx_r < nf);
        chk_idx_nxt = idx_r[8:0];
        if (idx_r < nf) idx_nxt = idx_r + 10'd1;
        if (chk_v_r && !fr_rd.valid) begin
          fr_we = 1'b1; fr_waddr = chk_idx_r;
          fr_wdata = '{valid: 1'b1, refbit: 1'b1, page: tgt_r};
          pg_we = 1'b1; pg_waddr = tgt_r;
          pg_wdata = '{res: 1'b1, frame: chk_idx_r, stamp: uc_r};
          ld_done = 1'b1; ld_f = chk_idx_r; ld_ev = 1'b0;
        end else if ((idx_r >= nf) && !chk_v_r) begin
          full_nxt = 1'b1;
          state_nxt = S_POLICY;
        end
      end

      S_POLICY: begin
        hand_nxt = hand_fix;
        if (mode_r == pre_pkg::MODE_FIFO) begin
          victim_nxt = hand_fix;
          hand_nxt = (10'(hand_fix) + 10'd1 >= nf) ? 9'd0 : hand_fix + 9'd1;
          state_nxt = S_EV_RD;
        end else if (mode_r == pre_pkg::MODE_LRU) begin
          idx_nxt = 10'd0; chk_v_nxt = 1'b0; s2_v_nxt = 1'b0; best_v_nxt = 1'b0;
          state_nxt = S_LRU;
        end else begin
          state_nxt = S_CLK_RD;
        end
      end

      // Frame read, then page stamp read, then compare; first oldest wins.
      S_LRU: begin
        fr_raddr = idx_r[8:0];
        chk_v_nxt = (idx_r < nf);
        chk_idx_nxt = idx_r[8:0];
        if (idx_r < nf) idx_nxt = idx_r + 10'd1;
        pg_raddr = fr_rd.page;
        s2_v_nxt = chk_v_r;
        s2_idx_nxt = chk_idx_r;
        if (s2_v_r && (!best_v_r || (pg_rd.stamp < best_t_r))) begin
          best_v_nxt = 1'b1;
          best_f_nxt = s2_idx_r;
          best_t_nxt = pg_rd.stamp;
        end
        if ((idx_r >= nf) && !chk_v_r && !s2_v_r) begin
          victim_nxt = best_f_r;
          state_nxt = S_EV_RD;
        end
      end

      S_CLK_RD: begin
        fr_raddr = hand_r;
        state_nxt = S_CLK_CHK;
      end

      S_CLK_CHK: begin
        fr_raddr = hand_r;
        hand_nxt = (hand_inc >= nf) ? 9'd0 : hand_inc[8:0];
        if (fr_rd.refbit) begin
          fr_we = 1'b1; fr_waddr = hand_r;
          fr_wdata = '{valid: fr_rd.valid, refbit: 1'b0, page: fr_rd.page};
          state_nxt = S_CLK_RD;
        end else begin
          victim_nxt = hand_r;
          state_nxt = S_EV_RD;
        end
      end

      S_EV_RD: begin
        fr_raddr = victim_r;
        state_nxt = S_EV_WR;
      end

      // FIFO and LRU keep the frame's reference bit; Clock sets it.
      S_EV_WR: begin
        fr_raddr = victim_r;
        fr_we = 1'b1; fr_waddr = victim_r;
        fr_wdata = '{valid: 1'b1,
                     refbit: (mode_r[1] ? 1'b1 : fr_rd.refbit),
                     page: tgt_r};
        pg_we = 1'b1; pg_waddr = tgt_r;
        pg_wdata = '{res: 1'b1, frame: victim_r, stamp: uc_r};
        oldg_nxt = fr_rd.page;
        state_nxt = S_EV_CLR;
      end

      S_EV_CLR: begin
        pg_we = 1'b1; pg_waddr = oldg_r;
        pg_wdata = '0;
        ld_done = 1'b1; ld_f = victim_r; ld_ev = 1'b1;
      end

      // Looks for the next non-resident page after the referenced one.
      S_PRE_SCAN: begin
        pg_raddr = c_r;
        chk_v_nxt = (idx_r < (10'(total) - 10'd1));
        chk_idx_nxt = {1'b0, c_r};
        if (idx_r < (10'(total) - 10'd1)) begin
          idx_nxt = idx_r + 10'd1;
          c_nxt = (c_inc == total) ? 8'd0 : c_inc[7:0];
        end
        if (chk_v_r && !pg_rd.res) begin
          tgt_nxt = chk_idx_r[7:0];
          ld_start = 1'b1;
        end else if ((idx_r >= (10'(total) - 10'd1)) && !chk_v_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_fault_nxt = fault_r;
          o_frame_nxt = fdem_r;
          o_ev_nxt = ev_r;
          o_pre_nxt = pre_r;
          o_bad_nxt = bad_r;
          o_total_nxt = fcnt_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // End of a page load: demand loads may be followed by a pre-page search.
    if (ld_done) begin
      if (is_pre_r) begin
        pre_nxt = 1'b1;
        state_nxt = S_DONE;
      end else begin
        fdem_nxt = ld_f;
        ev_nxt = ld_ev;
        if (prep_r) begin
          uc_nxt = uc_r + 40'd1;
          is_pre_nxt = 1'b1;
          c_nxt = (g_inc == total) ? 8'd0 : g_inc[7:0];
          idx_nxt = 10'd0;
          chk_v_nxt = 1'b0;
          state_nxt = S_PRE_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
    end

    // Start of a page load: empty frames first, until they are known used up.
    if (ld_start) begin
      idx_nxt = 10'd0;
      chk_v_nxt = 1'b0;
      state_nxt = full_r ? S_POLICY : S_FILL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      mode_r <= 2'd0; prep_r <= 1'b0; shift_r <= 4'd5; pcnt_r <= 3'd1;
      for (int i = 0; i < 4; i++) ppg_r[i] <= 7'd1;
      idx_r <= 10'd0; chk_v_r <= 1'b0; s2_v_r <= 1'b0; best_v_r <= 1'b0;
      hand_r <= 9'd0; uc_r <= 40'd0; fcnt_r <= 32'd0; pdone_r <= 1'b0;
      full_r <= 1'b0; is_pre_r <= 1'b0; out_valid_r <= 1'b0; pp_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      mode_r <= mode_nxt; prep_r <= prep_nxt; shift_r <= shift_nxt; pcnt_r <= pcnt_nxt;
      for (int i = 0; i < 4; i++) ppg_r[i] <= ppg_nxt[i];
      idx_r <= idx_nxt; chk_v_r <= chk_v_nxt; s2_v_r <= s2_v_nxt; best_v_r <= best_v_nxt;
      hand_r <= hand_nxt; uc_r <= uc_nxt; fcnt_r <= fcnt_nxt; pdone_r <= pdone_nxt;
      full_r <= full_nxt; is_pre_r <= is_pre_nxt; out_valid_r <= out_valid_nxt;
      pp_r <= pp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pid_r <= pid_nxt; loc_r <= loc_nxt; g_r <= g_nxt; tgt_r <= tgt_nxt; c_r <= c_nxt;
    chk_idx_r <= chk_idx_nxt; s2_idx_r <= s2_idx_nxt; best_f_r <= best_f_nxt;
    best_t_r <= best_t_nxt; victim_r <= victim_nxt; oldg_r <= oldg_nxt;
    pbf_r <= pbf_nxt; pbg_r <= pbg_nxt; fdem_r <= fdem_nxt;
    ev_r <= ev_nxt; pre_r <= pre_nxt; fault_r <= fault_nxt; bad_r <= bad_nxt;
    o_fault_r <= o_fault_nxt; o_ev_r <= o_ev_nxt; o_pre_r <= o_pre_nxt; o_bad_r <= o_bad_nxt;
    o_frame_r <= o_frame_nxt; o_total_r <= o_total_nxt;
  end

endmodule

/* hdl/pre_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module pre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/tb.sv */
// Self-checking testbench for page_replacement_engine: request driver, result monitor,
// an internal page table predictor and an APB register writer. Depends on pre_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  pid;
    logic [15:0] loc;
  } mem_ref_t;

  typedef struct {
    logic        fault;
    logic [8:0]  frame;
    logic        evicted;
    logic        prefetched;
    logic [31:0] total;
    logic        bad;
  } ref_result_t;

  localparam int STALL_LIMIT = 20000;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [1:0]  in_process_id;
  logic [15:0] in_location;
  logic        out_valid, out_stall;
  logic        out_page_fault, out_evicted_valid, out_prefetch_done, out_bad_reference;
  logic [8:0]  out_frame_used;
  logic [31:0] out_fault_total;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  page_replacement_engine i_dut (.*);

  // Stimulus and expectation stores.
  mem_ref_t    pending_refs[$];
  ref_result_t expected_results[$];
  bit          failed;
  bit          req_taken;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned long_hold_cycles;
  int unsigned quiet_cycles;

  // Shadow copy of the engine: configuration and page/frame tables.
  logic [1:0]  sh_policy;
  logic        sh_prepage;
  logic [3:0]  sh_shift;
  logic [2:0]  sh_pcount;
  logic [6:0]  sh_ppg[4];
  bit          sh_resident[pre_pkg::PAGES];
  logic [39:0] sh_stamp[pre_pkg::PAGES];
  int          sh_frame_page[pre_pkg::FRAMES];
  bit          sh_frame_valid[pre_pkg::FRAMES];
  bit          sh_refbit[pre_pkg::FRAMES];
  int          sh_hand;
  logic [39:0] sh_clock;
  logic [31:0] sh_faults;
  bit          sh_preloaded;

  function automatic int live_procs();
    if (sh_pcount < 1) return 1;
    return (sh_pcount > 4) ? 4 : int'(sh_pcount);
  endfunction

  function automatic int proc_pages(int p);
    int v;
    v = sh_ppg[p];
    if (v < 1) v = 1;
    return (v > pre_pkg::MAX_PPG) ? pre_pkg::MAX_PPG : v;
  endfunction

  function automatic int page_base(int p);
    int b;
    b = 0;
    for (int i = 0; i < p; i++) b += proc_pages(i);
    return b;
  endfunction

  function automatic int frame_count();
    int f;
    f = 512 >> sh_shift;
    return (f == 0) ? 1 : f;
  endfunction

  function automatic void step_hand(int nf);
    sh_hand = (sh_hand + 1 >= nf) ? 0 : sh_hand + 1;
  endfunction

  // Places a global page in a frame, evicting by the selected policy when full.
  function automatic int place_page(int g, output bit evicted);
    int nf, f, guard;
    nf = frame_count();
    evicted = 0;
    for (int i = 0; i < nf; i++) begin
      if (!sh_frame_valid[i]) begin
        sh_frame_valid[i] = 1;
        sh_frame_page[i] = g;
        sh_refbit[i] = 1;
        sh_resident[g] = 1;
        return i;
      end
    end
    if (sh_hand >= nf) sh_hand = 0;
    if (sh_policy == pre_pkg::MODE_FIFO) begin
      f = sh_hand;
      step_hand(nf);
    end else if (sh_policy == pre_pkg::MODE_LRU) begin
      f = 0;
      for (int i = 1; i < nf; i++)
        if (sh_stamp[sh_frame_page[i]] < sh_stamp[sh_frame_page[f]]) f = i;
    end else begin
      guard = 0;
      while (guard <= nf && sh_refbit[sh_hand]) begin
        sh_refbit[sh_hand] = 0;
        step_hand(nf);
        guard++;
      end
      f = sh_hand;
      sh_refbit[f] = 1;
      step_hand(nf);
    end
    sh_resident[sh_frame_page[f]] = 0;
    sh_frame_page[f] = g;
    sh_resident[g] = 1;
    evicted = 1;
    return f;
  endfunction

  function automatic void preload_frames();
    int np, nf, share, b, f;
    np = live_procs();
    nf = frame_count();
    share = nf / np;
    for (int p = 0; p < np; p++) begin
      b = page_base(p);
      for (int j = 0; j < share && j < proc_pages(p); j++) begin
        f = share * p + j;
        if (f >= nf) break;
        sh_frame_valid[f] = 1;
        sh_frame_page[f] = b + j;
        sh_resident[b + j] = 1;
      end
    end
    sh_preloaded = 1;
  endfunction

  // Works out the result of one accepted request and updates the shadow tables.
  function automatic ref_result_t predict_reference(logic [1:0] pid, logic [15:0] loc);
    ref_result_t r;
    int page, g, total, c;
    bit ev, ev2;
    r = '{default: 0};
    if (!sh_preloaded) preload_frames();
    r.total = sh_faults;
    if (pid >= live_procs() || loc == 0) begin
      r.bad = 1;
      return r;
    end
    page = (int'(loc) - 1) >> sh_shift;
    if (page >= proc_pages(pid)) begin
      r.bad = 1;
      return r;
    end
    g = page_base(pid) + page;
    total = page_base(live_procs());
    sh_clock++;
    if (sh_resident[g]) begin
      sh_stamp[g] = sh_clock;
      for (int i = 0; i < frame_count(); i++)
        if (sh_frame_valid[i] && sh_frame_page[i] == g) begin
          sh_refbit[i] = 1;
          r.frame = 9'(i);
        end
    end else begin
      r.fault = 1;
      sh_faults++;
      r.frame = 9'(place_page(g, ev));
      r.evicted = ev;
      sh_stamp[g] = sh_clock;
      if (sh_prepage) begin
        sh_clock++;
        for (int k = 1; k < total; k++) begin
          c = (g + k) % total;
          if (!sh_resident[c]) begin
            void'(place_page(c, ev2));
            sh_stamp[c] = sh_clock;
            r.prefetched = 1;
            break;
          end
        end
      end
    end
    r.total = sh_faults;
    return r;
  endfunction

  // Clock.
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Request driver: a request leaves the queue only once the previous one was taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || req_taken) begin
      req_taken = 0;
      if (pending_refs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_process_id <= pending_refs[0].pid;
        in_location   <= pending_refs[0].loc;
        in_valid      <= 1;
        void'(pending_refs.pop_front());
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Receiver stall, with an optional long hold counted here.
  always @(negedge clk) begin
    if (long_hold_cycles > 0) begin
      long_hold_cycles--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic void check_bit(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, name, exp, act);
      failed = 1;
    end
  endfunction

  // Monitor: predicts on accepted requests, checks accepted results, and watches for hangs.
  always @(posedge clk) begin
    ref_result_t e;
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(),
                                predict_reference(in_process_id, in_location));
        req_taken = 1;
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result, fault_total %0d", $realtime, out_fault_total);
          failed = 1;
        end else begin
          e = expected_results.pop_front();
          check_bit("page_fault", 32'(e.fault), 32'(out_page_fault));
          check_bit("frame_used", 32'(e.frame), 32'(out_frame_used));
          check_bit("evicted_valid", 32'(e.evicted), 32'(out_evicted_valid));
          check_bit("prefetch_done", 32'(e.prefetched), 32'(out_prefetch_done));
          check_bit("fault_total", e.total, out_fault_total);
          check_bit("bad_reference", 32'(e.bad), 32'(out_bad_reference));
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[page_replacement_engine] ERROR");
        $finish;
      end
    end
  end

  // APB register write: setup cycle, then access cycle. The shadow follows the
  // engine's lock, so writes after the first request change nothing.
  task automatic write_reg(pre_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 5'(4 * int'(idx)); pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (!sh_preloaded) begin
      case (idx)
        pre_pkg::REG_POLICY:  sh_policy  = value[1:0];
        pre_pkg::REG_PREPAGE: sh_prepage = value[0];
        pre_pkg::REG_SHIFT:   sh_shift   = value[3:0];
        pre_pkg::REG_PCOUNT:  sh_pcount  = value[2:0];
        default:              sh_ppg[int'(idx) - int'(pre_pkg::REG_PPG0)] = value[6:0];
      endcase
    end
  endtask

  task automatic wait_all_done();
    while (pending_refs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic add_ref(int pid, int loc);
    mem_ref_t m;
    m = '{pid: 2'(pid), loc: 16'(loc)};
    pending_refs.insert(pending_refs.size(), m);
  endtask

  // Mostly references into a small working set per process, some noise.
  task automatic add_random_refs(int n);
    int pid, pg;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 85) begin
        pid = $urandom_range(3);
        pg = $urandom_range(0, (proc_pages(pid) > 12) ? 11 : proc_pages(pid) - 1);
        if ($urandom_range(9) == 0) pg = $urandom_range(0, proc_pages(pid) - 1);
        add_ref(pid, (pg << sh_shift) + $urandom_range(1, 1 << sh_shift));
      end else begin
        add_ref($urandom_range(3), $urandom_range(0, 65535));
      end
    end
  endtask

  initial begin
    rst_n = 0; in_valid = 0; out_stall = 0;
    in_process_id = 0; in_location = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    failed = 0; req_taken = 0; quiet_cycles = 0; long_hold_cycles = 0;
    send_idle_pct = 20; recv_idle_pct = 58;
    sh_policy = pre_pkg::MODE_FIFO; sh_prepage = 0; sh_shift = 4'd5; sh_pcount = 3'd1;
    foreach (sh_ppg[i]) sh_ppg[i] = 7'd1;
    foreach (sh_resident[i]) begin sh_resident[i] = 0; sh_stamp[i] = '0; end
    foreach (sh_frame_page[i]) begin
      sh_frame_page[i] = 0; sh_frame_valid[i] = 0; sh_refbit[i] = 0;
    end
    sh_hand = 0; sh_clock = '0; sh_faults = '0; sh_preloaded = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;

    // Eight frames, four processes with clamped page counts, Clock with pre-paging.
    write_reg(pre_pkg::REG_POLICY, 32'd2);
    write_reg(pre_pkg::REG_PREPAGE, 32'd1);
    write_reg(pre_pkg::REG_SHIFT, 32'd6);
    write_reg(pre_pkg::REG_PCOUNT, 32'd4);
    write_reg(pre_pkg::REG_PPG0, 32'd64);
    write_reg(pre_pkg::REG_PPG1, 32'd0);
    write_reg(pre_pkg::REG_PPG2, 32'd100);
    write_reg(pre_pkg::REG_PPG3, 32'd5);

    // Directed: field extremes, bad references, hits on preloaded pages.
    add_ref(0, 1);     add_ref(0, 4096);  add_ref(0, 4097);  add_ref(0, 0);
    add_ref(1, 64);    add_ref(1, 65);    add_ref(2, 4096);  add_ref(3, 320);
    add_ref(3, 321);   add_ref(3, 65535); add_ref(0, 32768); add_ref(2, 1);
    add_ref(0, 1);     add_ref(0, 65);    add_ref(0, 129);   add_ref(0, 193);
    add_ref(2, 2048);  add_ref(1, 1);     add_ref(3, 1);     add_ref(0, 4096);
    wait_all_done();

    // The receiver holds off while requests keep coming, so the engine backs up.
    long_hold_cycles = 3000;
    add_random_refs(175);
    wait_all_done();

    // Configuration is frozen now; these writes must have no effect.
    write_reg(pre_pkg::REG_POLICY, 32'd0);
    write_reg(pre_pkg::REG_SHIFT, 32'd9);
    send_idle_pct = 58; recv_idle_pct = 20;
    add_random_refs(175);
    wait_all_done();

    write_reg(pre_pkg::REG_POLICY, 32'd3);
    write_reg(pre_pkg::REG_PREPAGE, 32'd0);
    write_reg(pre_pkg::REG_SHIFT, 32'd0);
    write_reg(pre_pkg::REG_PCOUNT, 32'd7);
    send_idle_pct = 0; recv_idle_pct = 0;
    add_random_refs(170);
    wait_all_done();
    repeat (50) @(posedge clk);

    if (!failed) begin
      $display("[page_replacement_engine] OK");
    end else begin
      $display("[page_replacement_engine] ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
hdl/pre_pkg.sv
hdl/pre_ram.sv
hdl/page_replacement_engine.sv
tb/tb.sv
